>>> rtl/btnt_pkg.sv
// ----------------------------------------------------------------------------
// btnt_pkg
// Shared constants, types and helpers of the bit transition novelty tracker.
// ----------------------------------------------------------------------------
package btnt_pkg;

  localparam int NUM_FEATURE_BITS = 1024;
  localparam int WORD_BITS        = 32;
  localparam int FRACTION_BITS    = 16;

  localparam int FRAME_WORDS = (NUM_FEATURE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int POS_W       = 5;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int K_W         = BIT_W + 1;
  localparam int AVG_W       = FRACTION_BITS + 1;
  localparam int CNT_W       = 32;
  localparam int MUL_W       = AVG_W + CNT_W;
  localparam int AVG_DEPTH   = 2 * NUM_FEATURE_BITS;
  localparam int AVG_AW      = $clog2(AVG_DEPTH);
  localparam int STEP_W      = $clog2(AVG_W);

  localparam int THR_W   = 17;
  localparam int WARM_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 17'd655;
  localparam logic [WARM_W-1:0] WARMUP_RST    = 16'd300;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_WORDS - 1);
  localparam logic [K_W-1:0]   LAST_K    = K_W'(2 * WORD_BITS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AVG_W - 1);

  localparam int OUT_DATA_W = 72;
  localparam int IN_DATA_W  = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic           load;
    logic           rd;
    logic           mul;
    logic           div;
    logic           wr;
    logic           finish;
    logic [K_W-1:0] k;
  } btnt_cmd_t;

  typedef struct packed {
    logic out_free;
  } btnt_status_t;

  // Feature bit lies inside the frame
  function automatic logic bit_valid(input logic [POS_W-1:0] pos,
                                     input logic [BIT_W-1:0] b);
    logic [AVG_AW:0] g;
    begin
      g = (AVG_AW+1)'(pos) * (AVG_AW+1)'(WORD_BITS) + (AVG_AW+1)'(b);
      return g < (AVG_AW+1)'(NUM_FEATURE_BITS);
    end
  endfunction

endpackage

>>> rtl/btnt_ram.sv
// ----------------------------------------------------------------------------
// btnt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module btnt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/btnt_ctrl.sv
// ----------------------------------------------------------------------------
// btnt_ctrl
// Sequencer: walks the 64 averages of a word through read, multiply,
// divide and write-back, then hands the result to the output register.
// ----------------------------------------------------------------------------
module btnt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  btnt_pkg::btnt_status_t status,
  output btnt_pkg::btnt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_DIV,
    S_WR,
    S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [btnt_pkg::K_W-1:0]     k_r, k_nxt;
  logic [btnt_pkg::STEP_W-1:0]  step_r, step_nxt;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.k      = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == btnt_pkg::LAST_STEP) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (k_r == btnt_pkg::LAST_K) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

>>> rtl/btnt_dp.sv
// ----------------------------------------------------------------------------
// btnt_dp
// Datapath: configuration, frame state, average memory, multiplier,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module btnt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  btnt_pkg::btnt_cmd_t             cmd,
  output btnt_pkg::btnt_status_t          status,
  input  logic                            cfg_wr_en,
  input  logic [btnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btnt_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [btnt_pkg::WORD_BITS-1:0]  in_word,
  input  logic                            in_prev_zero,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btnt_pkg::POS_W-1:0]      out_word_index,
  output logic [btnt_pkg::WORD_BITS-1:0]  out_rise_mask,
  output logic [btnt_pkg::WORD_BITS-1:0]  out_fall_mask,
  output logic                            out_word_relevant,
  output logic                            out_frame_end,
  output logic                            out_frame_relevant
);

  localparam int WB = btnt_pkg::WORD_BITS;

  // configuration
  logic [btnt_pkg::THR_W-1:0]  thr_r;
  logic                        report_all_r;
  logic [btnt_pkg::WARM_W-1:0] warm_r;

  // frame state
  logic [btnt_pkg::CNT_W-1:0]  fc_r, fc_nxt;
  logic [btnt_pkg::POS_W-1:0]  pos_r;
  logic                        seen_r;
  logic                        first_r;
  logic [WB-1:0]               prev_mem [btnt_pkg::FRAME_WORDS];

  // word working set
  logic [WB-1:0]               cur_r, prev_r;
  logic [WB-1:0]               rise_rel_r, fall_rel_r;
  logic [btnt_pkg::MUL_W-1:0]  num_r, den_r;
  logic [btnt_pkg::AVG_W-1:0]  q_r;

  // output register
  logic                        out_valid_r;
  logic [btnt_pkg::POS_W-1:0]  o_idx_r;
  logic [WB-1:0]               o_rise_r, o_fall_r;
  logic                        o_wrel_r, o_end_r, o_frel_r;

  logic [btnt_pkg::BIT_W-1:0]  b;
  logic                        dir, up, down, hit, bvalid, warm;
  logic [btnt_pkg::AVG_AW-1:0] addr;
  logic [btnt_pkg::AVG_W-1:0]  rdata, f;
  logic [WB-1:0]               vmask;
  logic                        ge, word_rel, last;

  assign b      = cmd.k[btnt_pkg::BIT_W-1:0];
  assign dir    = cmd.k[btnt_pkg::K_W-1];
  assign up     = cur_r[b] & ~prev_r[b];
  assign down   = prev_r[b] & ~cur_r[b];
  assign hit    = dir ? down : up;
  assign bvalid = btnt_pkg::bit_valid(pos_r, b);
  assign warm   = fc_r > btnt_pkg::CNT_W'(warm_r);
  assign addr   = btnt_pkg::AVG_AW'(dir) * btnt_pkg::AVG_AW'(btnt_pkg::NUM_FEATURE_BITS)
                + btnt_pkg::AVG_AW'(pos_r) * btnt_pkg::AVG_AW'(WB)
                + btnt_pkg::AVG_AW'(b);
  assign f      = first_r ? '0 : rdata;
  assign ge     = num_r >= den_r;

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      vmask[i] = btnt_pkg::bit_valid(pos_r, btnt_pkg::BIT_W'(i));
    end
  end

  always_comb begin
    fc_nxt = fc_r;
    if (pos_r == '0 && fc_r != '1) begin
      fc_nxt = fc_r + 1'b1;
    end
  end

  assign word_rel = |(rise_rel_r | fall_rel_r);
  assign last     = (pos_r == btnt_pkg::LAST_POS);

  btnt_ram #(
    .WIDTH (btnt_pkg::AVG_W),
    .DEPTH (btnt_pkg::AVG_DEPTH)
  ) u_avg_ram (
    .clk   (clk),
    .we    (cmd.wr & bvalid),
    .addr  (addr),
    .wdata (q_r),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= btnt_pkg::THRESHOLD_RST;
      report_all_r <= 1'b0;
      warm_r       <= btnt_pkg::WARMUP_RST;
      fc_r         <= '0;
      pos_r        <= '0;
      seen_r       <= 1'b0;
      first_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          btnt_pkg::CFG_THRESHOLD:  thr_r        <= cfg_wdata[btnt_pkg::THR_W-1:0];
          btnt_pkg::CFG_REPORT_ALL: report_all_r <= cfg_wdata[0];
          btnt_pkg::CFG_WARMUP:     warm_r       <= cfg_wdata[btnt_pkg::WARM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        fc_r    <= fc_nxt;
        // averages and previous bits are still unwritten in the first frame
        first_r <= (fc_nxt == btnt_pkg::CNT_W'(1));
        if (pos_r == '0) begin
          seen_r <= 1'b0;
        end
      end
      if (cmd.finish) begin
        pos_r       <= last ? '0 : pos_r + 1'b1;
        seen_r      <= seen_r | word_rel;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r      <= in_word & vmask;
      prev_r     <= (in_prev_zero || fc_nxt == btnt_pkg::CNT_W'(1)) ? '0 : prev_mem[pos_r];
      rise_rel_r <= '0;
      fall_rel_r <= '0;
    end
    if (cmd.mul) begin
      num_r <= btnt_pkg::MUL_W'(f) * btnt_pkg::MUL_W'(fc_r - 1'b1)
             + (hit ? btnt_pkg::MUL_W'(1) << btnt_pkg::FRACTION_BITS : '0);
      den_r <= btnt_pkg::MUL_W'(fc_r) << (btnt_pkg::AVG_W - 1);
      q_r   <= '0;
    end
    if (cmd.div) begin
      if (ge) begin
        num_r <= num_r - den_r;
      end
      q_r   <= {q_r[btnt_pkg::AVG_W-2:0], ge};
      den_r <= den_r >> 1;
    end
    if (cmd.wr && bvalid && hit && warm && q_r < thr_r) begin
      if (dir) begin
        fall_rel_r[b] <= 1'b1;
      end else begin
        rise_rel_r[b] <= 1'b1;
      end
    end
    if (cmd.finish) begin
      prev_mem[pos_r] <= cur_r;
      o_idx_r  <= pos_r;
      o_rise_r <= report_all_r ? (cur_r & ~prev_r) : rise_rel_r;
      o_fall_r <= report_all_r ? (prev_r & ~cur_r) : fall_rel_r;
      o_wrel_r <= word_rel;
      o_end_r  <= last;
      o_frel_r <= last & (seen_r | word_rel);
    end
  end

  assign status.out_free    = ~out_valid_r | out_ready;
  assign out_valid          = out_valid_r;
  assign out_word_index     = o_idx_r;
  assign out_rise_mask      = o_rise_r;
  assign out_fall_mask      = o_fall_r;
  assign out_word_relevant  = o_wrel_r;
  assign out_frame_end      = o_end_r;
  assign out_frame_relevant = o_frel_r;

endmodule

>>> rtl/bit_transition_novelty_tracker.sv
// ----------------------------------------------------------------------------
// bit_transition_novelty_tracker
// Per-bit rise/fall frequency tracking with novelty masks per frame word.
// ----------------------------------------------------------------------------
// Words: one at a time; a new request is accepted only once the previous word
//   has been handed to the output register. Each of the 64 averages takes a read,
//   a multiply, 17 divider steps and a write on the single average RAM port.
// Reset: rst_n synchronous, active low; clears control, frame count and config.
//   Averages and previous bits read as zero during the first frame, no sweep.
module bit_transition_novelty_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [btnt_pkg::IN_DATA_W-1:0]     in_tdata,   // frame_word
  input  logic                               in_tuser,   // previous_is_zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [btnt_pkg::OUT_DATA_W-1:0]    out_tdata,  // word_index, rise_mask, fall_mask, pad
  output logic [1:0]                         out_tuser,  // word_relevant, frame_relevant
  output logic                               out_tlast,  // frame_end
  input  logic                               cfg_wr_en,
  input  logic [btnt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btnt_pkg::CFG_W-1:0]         cfg_wdata
);

  btnt_pkg::btnt_cmd_t    cmd;
  btnt_pkg::btnt_status_t status;
  logic [btnt_pkg::POS_W-1:0]     word_index;
  logic [btnt_pkg::WORD_BITS-1:0] rise_mask, fall_mask;
  logic                           word_relevant, frame_relevant;

  btnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  btnt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_word            (in_tdata[btnt_pkg::WORD_BITS-1:0]),
    .in_prev_zero       (in_tuser),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_word_index     (word_index),
    .out_rise_mask      (rise_mask),
    .out_fall_mask      (fall_mask),
    .out_word_relevant  (word_relevant),
    .out_frame_end      (out_tlast),
    .out_frame_relevant (frame_relevant)
  );

  assign out_tdata = {3'b000, fall_mask, rise_mask, word_index};
  assign out_tuser = {frame_relevant, word_relevant};

endmodule

>>> rtl/btnt_checker.sv
// ----------------------------------------------------------------------------
// btnt_checker
// Port-level checks of the novelty tracker, bound to the top level.
// ----------------------------------------------------------------------------
module btnt_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [btnt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_frame_rel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("frame_relevant outside last word");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[4:0] == btnt_pkg::LAST_POS)))
    else $error("frame_end does not match word index");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while word in progress");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bit_transition_novelty_tracker btnt_port_checker u_btnt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> bench/btnt_checker.sv
// ----------------------------------------------------------------------------
// btnt_checker
// Watches the request, result and register ports of the novelty tracker,
// predicts each result word from its own copy of the state, and compares.
// ----------------------------------------------------------------------------
module btnt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [btnt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [btnt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic [1:0]                          out_tuser,
  input  logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [btnt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btnt_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                  errors,
  output int                                  pending,
  output int                                  words_checked,
  output int                                  relevant_words
);
  import btnt_pkg::*;

  typedef struct packed {
    logic [4:0]  word_index;
    logic [31:0] rise_mask;
    logic [31:0] fall_mask;
    logic        word_relevant;
    logic        frame_end;
    logic        frame_relevant;
  } word_report_t;

  word_report_t report_q[$];

  logic [THR_W-1:0]  thr;
  logic              report_all;
  logic [WARM_W-1:0] warmup;
  logic [31:0]       prev_frame [FRAME_WORDS];
  logic [16:0]       avg_mem [AVG_DEPTH];
  logic [31:0]       frames_seen;
  logic [4:0]        word_pos;
  logic              seen_rel;

  function automatic logic [16:0] blend(logic [16:0] f, logic hit, logic [31:0] n);
    logic [63:0] num;
    num = 64'(f) * 64'(n - 32'd1) + (hit ? 64'd65536 : 64'd0);
    return 17'(num / 64'(n));
  endfunction

  task automatic predict_word(logic [31:0] cur, logic pz);
    word_report_t r;
    logic [31:0] prev, rise_all, fall_all, rise_rel, fall_rel;
    logic warm;
    int g;
    prev = pz ? 32'd0 : prev_frame[word_pos];
    rise_all = 0; fall_all = 0; rise_rel = 0; fall_rel = 0;
    if (word_pos == 0) begin
      seen_rel = 0;
      if (frames_seen != 32'hFFFF_FFFF) frames_seen++;
    end
    warm = frames_seen > 32'(warmup);
    for (int b = 0; b < 32; b++) begin
      g = word_pos * 32 + b;
      avg_mem[g] = blend(avg_mem[g], cur[b] & ~prev[b], frames_seen);
      avg_mem[g + NUM_FEATURE_BITS] =
        blend(avg_mem[g + NUM_FEATURE_BITS], prev[b] & ~cur[b], frames_seen);
      if (cur[b] & ~prev[b]) begin
        rise_all[b] = 1;
        if (warm && avg_mem[g] < thr) rise_rel[b] = 1;
      end
      if (prev[b] & ~cur[b]) begin
        fall_all[b] = 1;
        if (warm && avg_mem[g + NUM_FEATURE_BITS] < thr) fall_rel[b] = 1;
      end
    end
    prev_frame[word_pos] = cur;
    if ((rise_rel | fall_rel) != 0) seen_rel = 1;
    r.word_index     = word_pos;
    r.rise_mask      = report_all ? rise_all : rise_rel;
    r.fall_mask      = report_all ? fall_all : fall_rel;
    r.word_relevant  = (rise_rel | fall_rel) != 0;
    r.frame_end      = word_pos == LAST_POS;
    r.frame_relevant = r.frame_end && seen_rel;
    report_q.insert(report_q.size(), r);
    word_pos = r.frame_end ? 5'd0 : word_pos + 5'd1;
  endtask

  always @(posedge clk) begin
    word_report_t exp_r, act_r;
    if (!rst_n) begin
      report_q.delete();
      thr = THRESHOLD_RST; report_all = 0; warmup = WARMUP_RST;
      foreach (prev_frame[i]) prev_frame[i] = 0;
      foreach (avg_mem[i]) avg_mem[i] = 0;
      frames_seen = 0; word_pos = 0; seen_rel = 0;
      errors = 0; words_checked = 0; relevant_words = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        act_r.word_index     = out_tdata[4:0];
        act_r.rise_mask      = out_tdata[36:5];
        act_r.fall_mask      = out_tdata[68:37];
        act_r.word_relevant  = out_tuser[0];
        act_r.frame_end      = out_tlast;
        act_r.frame_relevant = out_tuser[1];
        words_checked++;
        if (act_r.word_relevant) relevant_words++;
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, act_r);
        end else begin
          exp_r = report_q.pop_front();
          if (exp_r.word_index != act_r.word_index) begin
            errors++;
            $display("%0t: word_index exp %0d got %0d", $time,
                     exp_r.word_index, act_r.word_index);
          end
          if (exp_r.rise_mask != act_r.rise_mask) begin
            errors++;
            $display("%0t: rise_mask exp %h got %h", $time,
                     exp_r.rise_mask, act_r.rise_mask);
          end
          if (exp_r.fall_mask != act_r.fall_mask) begin
            errors++;
            $display("%0t: fall_mask exp %h got %h", $time,
                     exp_r.fall_mask, act_r.fall_mask);
          end
          if (exp_r.word_relevant != act_r.word_relevant) begin
            errors++;
            $display("%0t: word_relevant exp %0d got %0d", $time,
                     exp_r.word_relevant, act_r.word_relevant);
          end
          if (exp_r.frame_end != act_r.frame_end) begin
            errors++;
            $display("%0t: frame_end exp %0d got %0d", $time,
                     exp_r.frame_end, act_r.frame_end);
          end
          if (exp_r.frame_relevant != act_r.frame_relevant) begin
            errors++;
            $display("%0t: frame_relevant exp %0d got %0d", $time,
                     exp_r.frame_relevant, act_r.frame_relevant);
          end
        end
      end
      if (in_tvalid && in_tready) predict_word(in_tdata, in_tuser);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_THRESHOLD:  thr = cfg_wdata[THR_W-1:0];
          CFG_REPORT_ALL: report_all = cfg_wdata[0];
          CFG_WARMUP:     warmup = cfg_wdata[WARM_W-1:0];
          default: ;
        endcase
      end
    end
    pending = report_q.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of feature words through the novelty tracker under several
// register settings, with random idling on both channels; the checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import btnt_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // frame_word
  logic                  in_tuser;   // previous_is_zero
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // word_index, rise_mask, fall_mask, pad
  logic [1:0]            out_tuser;  // word_relevant, frame_relevant
  logic                  out_tlast;  // frame_end
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  int errors, pending, words_checked, relevant_words;
  int words_sent;
  logic quiet;
  logic hold_req;
  logic [31:0] last_frame [FRAME_WORDS];
  logic [4:0]  gen_pos;

  bit_transition_novelty_tracker dut (.*);

  btnt_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    int g;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (6000) @(negedge clk);
        hold_req = 0;
      end else if (quiet) begin
        out_tready <= 1;
      end else begin
        g = pick_gap();
        if (g == 0) out_tready <= 1;
        else begin
          out_tready <= 0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge
  task automatic send_word(logic [31:0] w, logic pz);
    int g;
    in_tvalid <= 1;
    in_tdata  <= w;
    in_tuser  <= pz;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    last_frame[gen_pos] = w;
    gen_pos++;
    words_sent++;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [31:0] w;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      w = last_frame[gen_pos];
      if (r < 70) begin
        // sparse flips keep most averages low
        repeat ($urandom_range(0, 2)) w[$urandom_range(0, 31)] ^= 1'b1;
      end else if (r < 85) begin
      end else if (r < 95) w = $urandom;
      else w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      send_word(w, $urandom_range(0, 99) < 3);
    end
  endtask

  // Drain, then write the registers while the block is idle
  task automatic set_regs(logic [THR_W-1:0] t, logic all, logic [WARM_W-1:0] wu);
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= CFG_THRESHOLD;  cfg_wdata <= t;
    @(negedge clk);
    cfg_index <= CFG_REPORT_ALL; cfg_wdata <= CFG_W'(all);
    @(negedge clk);
    cfg_index <= CFG_WARMUP;     cfg_wdata <= CFG_W'(wu);
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    cfg_wr_en = 0; cfg_index = 0; cfg_wdata = 0;
    quiet = 0; hold_req = 0; words_sent = 0; gen_pos = 0;
    foreach (last_frame[i]) last_frame[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset settings first, then every flip reported with no warm-up
    send_word(32'hFFFF_FFFF, 0);
    send_word(32'h0000_0000, 0);
    send_word(32'hAAAA_AAAA, 0);
    set_regs(17'd65536, 1, 16'd0);
    send_word(32'h5555_5555, 0);
    send_word(32'hFFFF_FFFF, 1);
    send_word(32'h8000_0001, 0);
    send_word(32'h0000_0000, 1);
    for (int i = 0; i < 26; i++) send_word(i[0] ? 32'hFFFF_FFFF : 32'h0, i % 5 == 0);
    for (int i = 0; i < 14; i++) send_word(last_frame[gen_pos] ^ (32'h1 << i), 0);

    set_regs(17'd655, 0, 16'd0);
    send_random(250);

    set_regs(17'd0, 1, 16'd65535);
    send_random(200);

    set_regs(17'd65536, 0, 16'd2);
    quiet = 1;
    send_random(200);
    quiet = 0;

    set_regs(17'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)),
             16'($urandom_range(0, 20)));
    cfg_wr_en <= 1; cfg_index <= 2'd3; cfg_wdata <= 17'($urandom);
    @(negedge clk);
    cfg_wr_en <= 0;
    send_random(250);

    set_regs(17'd20000, 0, 16'd10);
    hold_req = 1;
    send_random(300);

    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (1400) @(posedge clk);
    $display("ran %0d words (%0d frames) over seven register settings;", words_sent,
             words_sent / FRAME_WORDS);
    $display("checked %0d result words, %0d flagged relevant", words_checked,
             relevant_words);
    if (errors == 0 && words_checked == words_sent) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
